@@ rtl/core/svd_pkg.sv @@
// Package for the six-bit-group varint decoder: item types, status codes and constants.
`default_nettype none
package svd_pkg;

    // Default number of value bits that are kept.
    localparam int SVD_VALUE_WIDTH = 32;

    // Width of the delivered value field.
    localparam int SVD_OUT_WIDTH = 32;

    // Number of result entries in a bundle; one byte causes at most two results.
    localparam int SVD_MAX_RESULTS = 3;

    // Group shift that marks every further data bit as beyond the kept width.
    localparam logic [5:0] SVD_SHIFT_SAT = 6'd63;

    // Result status codes.
    localparam logic [1:0] SVD_ST_OK        = 2'd0;
    localparam logic [1:0] SVD_ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] SVD_ST_TRUNCATED = 2'd2;

    // One input item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [SVD_OUT_WIDTH-1:0] decoded_value;
        logic [1:0]               status;
        logic                     last_of_run;
    } t_out_item;

    // All results caused by one byte, first result in entry 0.
    typedef struct packed {
        logic [1:0]                          count;
        t_out_item [SVD_MAX_RESULTS-1:0]     items;
    } t_svd_bundle;

endpackage
`default_nettype wire

@@ rtl/core/svd_in_reg.sv @@
// Input register of the varint decoder: holds one accepted byte until the decoder takes it.
`default_nettype none
module svd_in_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire svd_pkg::t_in_item i_item,
    input  wire logic              i_sink_ready,
    output logic                   o_take,
    output svd_pkg::t_in_item      o_item
);
    import svd_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // The held item moves on when the result side can take its results.
    assign o_take  = r_valid && i_sink_ready;
    assign o_ready = !r_valid || i_sink_ready;
    assign o_item  = r_item;

    // Valid flag of the register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload is loaded whenever a new item is accepted.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/svd_decode.sv @@
// Decoder core: bit reservoir, value state and the extraction of up to two groups per byte.
`default_nettype none
module svd_decode #(
    parameter int VALUE_WIDTH = svd_pkg::SVD_VALUE_WIDTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire svd_pkg::t_in_item i_item,
    output svd_pkg::t_svd_bundle   o_bundle
);
    import svd_pkg::*;

    // State of the value under construction.
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] accum;
        logic [5:0]             shift;
        logic                   ovf;
        logic                   in_value;
    } t_vstate;

    localparam t_vstate VSTATE_CLEAR = '{accum: '0, shift: '0, ovf: 1'b0, in_value: 1'b0};

    logic [4:0] r_holding;
    logic [2:0] r_level;
    t_vstate    r_vs;

    logic [4:0]  n_holding;
    logic [2:0]  n_level;
    t_vstate     n_vs;

    // Adds one group to the value state.
    function automatic t_vstate f_take(input t_vstate st, input logic [5:0] grp);
        t_vstate     nx;
        logic [63:0] wide;
        logic [6:0]  pos;
        logic [6:0]  sum;
        nx = st;
        if (st.shift == SVD_SHIFT_SAT) begin
            if (grp[4:0] != 5'd0) begin
                nx.ovf = 1'b1;
            end
        end else begin
            for (int i = 0; i < 5; i++) begin
                pos = 7'(st.shift) + 7'(i);
                if (grp[i] && (pos >= 7'(VALUE_WIDTH))) begin
                    nx.ovf = 1'b1;
                end
            end
            wide     = 64'(grp[4:0]) << st.shift;
            nx.accum = st.accum | wide[VALUE_WIDTH-1:0];
        end
        if (grp[5]) begin
            sum         = 7'(st.shift) + 7'd5;
            nx.shift    = (sum >= 7'(SVD_SHIFT_SAT)) ? SVD_SHIFT_SAT : sum[5:0];
            nx.in_value = 1'b1;
        end
        return nx;
    endfunction

    // Low output bits of the accumulated value.
    function automatic logic [SVD_OUT_WIDTH-1:0] f_value(input t_vstate st);
        logic [63:0] ext;
        ext = 64'(st.accum);
        return ext[SVD_OUT_WIDTH-1:0];
    endfunction

    // Group extraction, result collection and truncation for one byte.
    always_comb begin
        logic [2:0]  lvl;
        logic [12:0] bits;
        logic [3:0]  total;
        logic        two;
        t_vstate     st;
        logic [1:0]  n;

        lvl   = (r_level > 3'd5) ? 3'd5 : r_level;
        bits  = 13'(r_holding) | (13'(i_item.data_byte) << lvl);
        total = 4'(lvl) + 4'd8;
        two   = (total >= 4'd12);
        n     = 2'd0;
        o_bundle = '0;

        // First group.
        st = f_take(r_vs, bits[5:0]);
        if (!bits[5]) begin
            o_bundle.items[n].decoded_value = f_value(st);
            o_bundle.items[n].status        = st.ovf ? SVD_ST_OVERFLOW : SVD_ST_OK;
            n  = n + 2'd1;
            st = VSTATE_CLEAR;
        end

        // Second group when the held bits and the byte together supply twelve or more bits.
        if (two) begin
            st = f_take(st, bits[11:6]);
            if (!bits[11]) begin
                o_bundle.items[n].decoded_value = f_value(st);
                o_bundle.items[n].status        = st.ovf ? SVD_ST_OVERFLOW : SVD_ST_OK;
                n  = n + 2'd1;
                st = VSTATE_CLEAR;
            end
            n_holding = {4'd0, bits[12]};
            n_level   = 3'(total - 4'd12);
        end else begin
            n_holding = bits[10:6];
            n_level   = 3'(total - 4'd6);
        end

        // Stream end: an open value is reported as truncated, pad bits are dropped.
        if (i_item.end_of_stream) begin
            if (st.in_value) begin
                o_bundle.items[n].decoded_value = f_value(st);
                o_bundle.items[n].status        = SVD_ST_TRUNCATED;
                n  = n + 2'd1;
                st = VSTATE_CLEAR;
            end
            n_holding = 5'd0;
            n_level   = 3'd0;
        end

        // Mark the final result of this byte.
        for (int k = 0; k < SVD_MAX_RESULTS; k++) begin
            o_bundle.items[k].last_of_run = (2'(k + 1) == n);
        end
        o_bundle.count = n;
        n_vs           = st;
    end

    // State registers advance once per byte taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holding <= 5'd0;
            r_level   <= 3'd0;
            r_vs      <= VSTATE_CLEAR;
        end else if (i_take) begin
            r_holding <= n_holding;
            r_level   <= n_level;
            r_vs      <= n_vs;
        end
    end

    // The reservoir never holds a full group.
    a_level_below_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= 3'd5)
        else $error("bit reservoir holds six or more bits");

    // After a final byte the reservoir and value state start afresh.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_item.end_of_stream) |=> (r_level == 3'd0 && !r_vs.in_value))
        else $error("state not cleared after end of stream");

    // One byte never causes more than two results.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> (o_bundle.count <= 2'd2))
        else $error("more than two results for one byte");

endmodule
`default_nettype wire

@@ rtl/core/svd_result_buf.sv @@
// Result buffer: holds one byte's results and delivers one item per cycle while ready.
`default_nettype none
module svd_result_buf (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire svd_pkg::t_svd_bundle i_bundle,
    output logic                      o_can_load,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output svd_pkg::t_out_item        o_item
);
    import svd_pkg::*;

    logic [1:0]                      r_count;
    t_out_item [SVD_MAX_RESULTS-1:0] r_items;
    logic                            pop;

    assign o_valid    = (r_count != 2'd0);
    assign o_item     = r_items[0];
    assign pop        = o_valid && i_ready;
    // A new byte's results may enter once the buffer is empty after this cycle.
    assign o_can_load = (r_count == 2'd0) || (r_count == 2'd1 && i_ready);

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (i_load) begin
            r_count <= i_bundle.count;
        end else if (pop) begin
            r_count <= r_count - 2'd1;
        end
    end

    // Entries shift towards the head as items leave.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_items <= i_bundle.items;
        end else if (pop) begin
            for (int k = 0; k < SVD_MAX_RESULTS - 1; k++) begin
                r_items[k] <= r_items[k + 1];
            end
        end
    end

    // The only item left is the last of its byte.
    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) |-> r_items[0].last_of_run)
        else $error("last remaining item not marked last of run");

    // With further items behind it, the head is not the last of its byte.
    a_head_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count > 2'd1) |-> !r_items[0].last_of_run)
        else $error("head item wrongly marked last of run");

    // Loading never overwrites items still to be delivered.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_count == 2'd0 || (r_count == 2'd1 && pop)))
        else $error("results loaded over undelivered items");

endmodule
`default_nettype wire

@@ rtl/core/six_bit_varint_decoder_top.sv @@
// Top level of the six-bit-group varint decoder.
// Bytes enter least significant bit first and are cut into 6-bit groups (5 data bits, bit 5
// set means the value continues, low group first). An item passes the input register and the
// result buffer before its first result. A new byte is taken every cycle while each byte has
// at most one result and the receiver is ready; a byte with two results (two finished values,
// or a value and a truncation at stream end) stalls the input, as the buffer delivers one item
// per cycle to a ready receiver, loading the next byte's results only as its last item leaves.
// Values keep VALUE_WIDTH bits; a set data bit beyond that gives overflow status.
`default_nettype none
module six_bit_varint_decoder_top #(
    parameter int VALUE_WIDTH = svd_pkg::SVD_VALUE_WIDTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire svd_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output svd_pkg::t_out_item     o_out_data
);
    import svd_pkg::*;

    logic        take;
    logic        can_load;
    t_in_item    held_item;
    t_svd_bundle bundle;

    // Input register.
    svd_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_item       (i_in_data),
        .i_sink_ready (can_load),
        .o_take       (take),
        .o_item       (held_item)
    );

    // Group extraction and value state.
    svd_decode #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_item   (held_item),
        .o_bundle (bundle)
    );

    // Result buffer.
    svd_result_buf u_result_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take),
        .i_bundle   (bundle),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_item     (o_out_data)
    );

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the six-bit-group varint decoder, with its own decoding model.
module tb;
    import svd_pkg::*;

    // Cycles without any handshake before the run is declared hung.
    localparam int HANG_LIMIT = 2000;
    // Number of mismatch lines printed before further ones are only counted.
    localparam int PRINT_LIMIT = 20;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    t_in_item   i_in_data = '0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_out_item  o_out_data;

    // Model state of the decoder.
    logic [4:0]  held_bits = '0;
    int          held_count = 0;
    logic [31:0] value_acc = '0;
    logic [5:0]  group_pos = '0;
    bit          value_overflow = 1'b0;
    bit          value_open = 1'b0;

    t_out_item   expected_results[$];

    int send_gap_pct = 0;
    int recv_gap_pct = 0;
    int recv_hold_left = 0;
    int bytes_sent = 0;
    int results_seen = 0;
    int status_seen[3] = '{0, 0, 0};
    int mismatch_count = 0;
    int quiet_cycles = 0;

    six_bit_varint_decoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Clock with a period of four time units.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Clears the value under construction.
    function automatic void clear_value();
        value_acc = '0;
        group_pos = '0;
        value_overflow = 1'b0;
        value_open = 1'b0;
    endfunction

    // Adds one 6-bit group to the open value; returns 1 when the value is complete.
    function automatic bit add_group(input logic [5:0] grp);
        logic [63:0] placed;
        logic [63:0] lost;
        placed = '0;
        lost = '0;
        if (group_pos >= SVD_SHIFT_SAT) begin
            if (grp[4:0] != 5'd0) value_overflow = 1'b1;
        end else begin
            placed = 64'(grp[4:0]) << group_pos;
            if (group_pos > 6'd59) lost = 64'(grp[4:0]) >> (7'd64 - 7'(group_pos));
            if (placed[63:32] != '0 || lost != '0) value_overflow = 1'b1;
            value_acc = value_acc | placed[31:0];
        end
        if (grp[5]) begin
            group_pos = (7'(group_pos) + 7'd5 >= 7'(SVD_SHIFT_SAT)) ? SVD_SHIFT_SAT
                                                                 : group_pos + 6'd5;
            value_open = 1'b1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Works out the results of one accepted byte and queues them.
    task automatic decode_byte(input logic [7:0] b, input logic eos);
        logic [12:0] window;
        int          avail;
        t_out_item   res[$];
        t_out_item   one;
        window = 13'(held_bits) | (13'(b) << held_count);
        avail = held_count + 8;
        while (avail >= 6) begin
            if (add_group(window[5:0])) begin
                one.decoded_value = value_acc;
                one.status = value_overflow ? SVD_ST_OVERFLOW : SVD_ST_OK;
                one.last_of_run = 1'b0;
                res.push_back(one);
                clear_value();
            end
            window = window >> 6;
            avail -= 6;
        end
        held_bits = window[4:0];
        held_count = avail;
        // A value still open at the end of the stream is reported as truncated.
        if (eos) begin
            if (value_open) begin
                one.decoded_value = value_acc;
                one.status = SVD_ST_TRUNCATED;
                one.last_of_run = 1'b0;
                res.push_back(one);
                clear_value();
            end
            held_bits = '0;
            held_count = 0;
        end
        if (res.size() > 0) res[res.size()-1].last_of_run = 1'b1;
        foreach (res[i]) expected_results.push_back(res[i]);
    endtask

    // Offers one byte, with random gaps before it, and waits until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        t_in_item it;
        it.data_byte = b;
        it.end_of_stream = eos;
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        decode_byte(b, eos);
        bytes_sent++;
    endtask

    // Stops offering and waits until every expected result has been delivered.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("ERROR at %0t: %s is 0x%0h, model gives 0x%0h", $time, what, got, want);
    endtask

    // Receiver: random stalls, or a long hold when one has been requested.
    always @(negedge i_clk) begin
        if (recv_hold_left > 0) begin
            recv_hold_left = recv_hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // Compares each delivered result with the oldest expected one.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (o_out_data.status <= SVD_ST_TRUNCATED) status_seen[o_out_data.status]++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, value", o_out_data.decoded_value, 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.decoded_value !== want.decoded_value)
                    report_mismatch("decoded_value", o_out_data.decoded_value,
                                    want.decoded_value);
                if (o_out_data.status !== want.status)
                    report_mismatch("status", 32'(o_out_data.status), 32'(want.status));
                if (o_out_data.last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", 32'(o_out_data.last_of_run),
                                    32'(want.last_of_run));
            end
        end
    end

    // Ends the run if neither side moves an item for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                         HANG_LIMIT, expected_results.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Single-byte streams: all-zero, all-one and alternating bits, each ending the stream.
    task automatic test_stream_ends();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hAA, 1'b1);
        drain();
    endtask

    // Builds up held bits until one byte completes two groups, then a value plus truncation.
    task automatic test_two_values_per_byte();
        repeat (5) send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b1);
        drain();
    endtask

    // A run of continued all-ones groups that saturates the shift and overflows.
    task automatic test_long_value();
        repeat (10) send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        drain();
    endtask

    // Continued zero groups past the kept width must not be flagged as overflow.
    task automatic test_zero_continuations();
        repeat (2) begin
            send_byte(8'h20, 1'b0);
            send_byte(8'h08, 1'b0);
            send_byte(8'h82, 1'b0);
        end
        send_byte(8'h00, 1'b1);
        drain();
    endtask

    // The receiver holds off for a long stretch while bytes keep coming, so the input stalls.
    task automatic test_backpressure();
        recv_hold_left = 80;
        repeat (24) send_byte(8'($urandom()), 1'b0);
        send_byte(8'h00, 1'b1);
        drain();
    endtask

    // One stream of well-formed values, optionally cut short, padded out to whole bytes.
    task automatic send_stream(input bit broken);
        bit         stream_bits[$];
        int         n_values;
        int         n_groups;
        bit         rand_pad;
        bit         ends_stream;
        logic [4:0] data;
        logic [7:0] b;
        n_values = $urandom_range(1, 4);
        for (int v = 0; v < n_values; v++) begin
            n_groups = ($urandom_range(5) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 7);
            for (int g = 0; g < n_groups; g++) begin
                case ($urandom_range(3))
                    0: data = 5'h00;
                    1: data = 5'h1F;
                    default: data = 5'($urandom());
                endcase
                for (int k = 0; k < 5; k++) stream_bits.push_back(data[k]);
                stream_bits.push_back(g != n_groups - 1);
            end
        end
        if (broken) begin
            repeat ($urandom_range(1, 10))
                if (stream_bits.size() > 1) void'(stream_bits.pop_back());
        end
        rand_pad = $urandom_range(1);
        ends_stream = ($urandom_range(7) != 0);
        while (stream_bits.size() > 0) begin
            for (int k = 0; k < 8; k++) begin
                if (stream_bits.size() > 0) b[k] = stream_bits.pop_front();
                else b[k] = rand_pad ? 1'($urandom()) : 1'b0;
            end
            send_byte(b, (stream_bits.size() == 0) && ends_stream);
        end
    endtask

    // Mostly well-formed streams, some cut short, some raw noise bytes.
    task automatic test_random_streams(input int n_bytes);
        int start;
        int kind;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            kind = $urandom_range(9);
            if (kind <= 6) begin
                send_stream(1'b0);
            end else if (kind <= 8) begin
                send_stream(1'b1);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom()), ($urandom_range(3) == 0));
            end
        end
        drain();
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles a little, receiver a lot.
        send_gap_pct = 21;
        recv_gap_pct = 75;
        test_stream_ends();
        test_two_values_per_byte();
        test_long_value();
        test_zero_continuations();
        test_random_streams(70);

        // Sender idles a lot, receiver a little.
        send_gap_pct = 75;
        recv_gap_pct = 21;
        test_random_streams(70);

        // No idling on either side.
        send_gap_pct = 0;
        recv_gap_pct = 0;
        test_backpressure();
        test_random_streams(70);

        $display("Run covered %0d bytes: directed cases, a long receiver hold and random streams.",
                 bytes_sent);
        $display("Results checked: %0d (ok %0d, overflow %0d, truncated %0d).", results_seen,
                 status_seen[0], status_seen[1], status_seen[2]);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
